// ----- rtl/core/assert_macros.svh -----
// Assertion helpers, included by the top-level engine module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

// ----- rtl/core/tcce_pkg.sv -----
package tcce_pkg;

  localparam int unsigned SCREEN_COLS_DEF = 80;
  localparam int unsigned SCREEN_ROWS_DEF = 25;

  localparam int unsigned CMD_FIFO_DEPTH = 4;
  localparam int unsigned RES_FIFO_DEPTH = 2;

  localparam logic [3:0] INIT_FILL_RESET = 4'd10;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BLOCK = 8'hDB;

  // tab stops every 8 columns
  localparam int unsigned TAB_BITS = 3;

  typedef enum logic [1:0] {
    REQ_PUTCHAR = 2'd0,
    REQ_INIT    = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_PIXEL   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOINIT  = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // The palette uses four component levels only.
  localparam logic [7:0] LEVEL [4] = '{8'd0, 8'd85, 8'd170, 8'd255};

  // Level codes per palette entry: red [5:4], green [3:2], blue [1:0].
  localparam logic [5:0] PAL_LVL [16] = '{
    6'b00_00_00, 6'b00_00_10, 6'b00_10_00, 6'b00_10_10,
    6'b10_00_00, 6'b10_00_10, 6'b10_01_00, 6'b10_10_10,
    6'b01_01_01, 6'b01_01_11, 6'b01_11_01, 6'b01_11_11,
    6'b11_01_01, 6'b11_01_11, 6'b11_11_01, 6'b11_11_11
  };

  typedef struct packed {
    req_e        req;
    logic [7:0]  ch;
    logic [6:0]  x;
    logic [4:0]  y;
    logic        both_neg;
    logic        one_neg;
    logic        pix_ok;
    logic [10:0] pix_base;
    logic [3:0]  idx;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic        cell_write;
    logic [10:0] cell_index;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scroll_up;
    logic        fill_screen;
    logic [7:0]  fill_attr;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        last;
  } res_t;

endpackage

// ----- rtl/core/text_console_cursor_engine.sv -----
// Path: a command passes the 3-stage palette search, the command queue and the execute
//   stage on its way to the result side.
// Throughput: one command per cycle unless a full queue stalls; a pixel block gives
//   two results, one per cell write, as the execute stage writes one result per cycle.
// Reset (async, active low): cursor 0,0, background 0, not initialized, fill index 10,
//   pipeline and both queues empty; the block takes commands right after reset.
module text_console_cursor_engine #(
  parameter int unsigned ScreenCols = tcce_pkg::SCREEN_COLS_DEF,
  parameter int unsigned ScreenRows = tcce_pkg::SCREEN_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        ch_i,
  input  logic signed [7:0] col_i,
  input  logic signed [7:0] row_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_data_i,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        status_o,
  output logic              cell_write_o,
  output logic [10:0]       cell_index_o,
  output logic [7:0]        cell_char_o,
  output logic [7:0]        cell_attr_o,
  output logic              scroll_up_o,
  output logic              fill_screen_o,
  output logic [7:0]        fill_attr_o,
  output logic [6:0]        cursor_col_o,
  output logic [4:0]        cursor_row_o,
  output logic              last_o
);

  `include "assert_macros.svh"

  localparam int unsigned CmdW = $bits(tcce_pkg::cmd_t);
  localparam int unsigned ResW = $bits(tcce_pkg::res_t);

  tcce_pkg::cmd_t front_cmd, back_cmd;
  tcce_pkg::res_t back_res, out_res;
  logic [CmdW-1:0] cmd_q_data;
  logic [ResW-1:0] res_q_data;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic res_push, res_full;

  tcce_front #(
    .ScreenCols (ScreenCols),
    .ScreenRows (ScreenRows)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .req_type_i (req_type_i),
    .ch_i       (ch_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .cmd_o      (front_cmd),
    .cmd_push_o (cmd_push),
    .cmd_full_i (cmd_full)
  );

  tcce_fifo #(
    .Width (CmdW),
    .Depth (tcce_pkg::CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_q_data),
    .empty_o (cmd_empty)
  );

  assign back_cmd = cmd_q_data;

  tcce_back #(
    .ScreenCols (ScreenCols),
    .ScreenRows (ScreenRows)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (back_res),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  tcce_fifo #(
    .Width (ResW),
    .Depth (tcce_pkg::RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_q_data),
    .empty_o (empty)
  );

  assign out_res       = res_q_data;
  assign status_o      = out_res.status;
  assign cell_write_o  = out_res.cell_write;
  assign cell_index_o  = out_res.cell_index;
  assign cell_char_o   = out_res.cell_char;
  assign cell_attr_o   = out_res.cell_attr;
  assign scroll_up_o   = out_res.scroll_up;
  assign fill_screen_o = out_res.fill_screen;
  assign fill_attr_o   = out_res.fill_attr;
  assign cursor_col_o  = out_res.cursor_col;
  assign cursor_row_o  = out_res.cursor_row;
  assign last_o        = out_res.last;

  `ASSERT_IMPLIES(a_cursor_on_screen, clk_i, rst_ni, !empty,
    int'(cursor_col_o) < ScreenCols && int'(cursor_row_o) < ScreenRows)
  `ASSERT_IMPLIES(a_fill_homes_cursor, clk_i, rst_ni, res_push && back_res.fill_screen,
    back_res.cursor_col == '0 && back_res.cursor_row == '0)
  `ASSERT_IMPLIES(a_scroll_bottom_row, clk_i, rst_ni, res_push && back_res.scroll_up,
    int'(back_res.cursor_row) == ScreenRows - 1)
  // the second cell of a block waits at the head even while the result queue is full
  `ASSERT_NEXT(a_block_pair, clk_i, rst_ni, res_push && !back_res.last,
    back_res.last && back_res.cell_char == tcce_pkg::CH_BLOCK)

endmodule

// ----- rtl/core/tcce_fifo.sv -----
module tcce_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/tcce_front.sv -----
module tcce_front #(
  parameter int unsigned ScreenCols = tcce_pkg::SCREEN_COLS_DEF,
  parameter int unsigned ScreenRows = tcce_pkg::SCREEN_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         ch_i,
  input  logic signed [7:0]  col_i,
  input  logic signed [7:0]  row_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output tcce_pkg::cmd_t     cmd_o,
  output logic               cmd_push_o,
  input  logic               cmd_full_i
);

  logic advance;
  logic a_valid_q, b_valid_q, c_valid_q;

  tcce_pkg::cmd_t cmd_a_d, cmd_a_q, cmd_b_q, cmd_c_q;
  logic [15:0] sq_r_d [4];
  logic [15:0] sq_g_d [4];
  logic [15:0] sq_b_d [4];
  logic [15:0] sq_r_q [4];
  logic [15:0] sq_g_q [4];
  logic [15:0] sq_b_q [4];
  logic [19:0] dist_d [16];
  logic [19:0] dist_q [16];
  logic [19:0] grp_dist_d [4];
  logic [19:0] grp_dist_q [4];
  logic [3:0]  grp_idx_d [4];
  logic [3:0]  grp_idx_q [4];
  logic [3:0]  best_idx;

  // hold the whole pipe while the last stage cannot hand off
  assign advance    = !c_valid_q || !cmd_full_i;
  assign full_o     = !advance;
  assign cmd_push_o = c_valid_q && !cmd_full_i;

  // stage A: per-channel squared distances to the four levels, decode
  always_comb begin
    logic [7:0] dr, dg, db;
    for (int l = 0; l < 4; l++) begin
      dr = (red_i >= tcce_pkg::LEVEL[l]) ? red_i - tcce_pkg::LEVEL[l]
                                         : tcce_pkg::LEVEL[l] - red_i;
      dg = (green_i >= tcce_pkg::LEVEL[l]) ? green_i - tcce_pkg::LEVEL[l]
                                           : tcce_pkg::LEVEL[l] - green_i;
      db = (blue_i >= tcce_pkg::LEVEL[l]) ? blue_i - tcce_pkg::LEVEL[l]
                                          : tcce_pkg::LEVEL[l] - blue_i;
      sq_r_d[l] = 16'(dr) * 16'(dr);
      sq_g_d[l] = 16'(dg) * 16'(dg);
      sq_b_d[l] = 16'(db) * 16'(db);
    end
  end

  always_comb begin
    cmd_a_d          = '0;
    cmd_a_d.req      = tcce_pkg::req_e'(req_type_i);
    cmd_a_d.ch       = ch_i;
    cmd_a_d.both_neg = col_i[7] && row_i[7];
    cmd_a_d.one_neg  = col_i[7] ^ row_i[7];
    cmd_a_d.pix_ok   = !col_i[7] && !row_i[7]
                       && ({1'b0, col_i[6:0]} < 8'(ScreenCols / 2))
                       && ({1'b0, row_i[6:0]} < 8'(ScreenRows));
    // clamp to the screen; only read when both coordinates are non-negative
    cmd_a_d.x = ({1'b0, col_i[6:0]} >= 8'(ScreenCols)) ? 7'(ScreenCols - 1)
                                                       : col_i[6:0];
    cmd_a_d.y = ({1'b0, row_i[6:0]} >= 8'(ScreenRows)) ? 5'(ScreenRows - 1)
                                                       : row_i[4:0];
    cmd_a_d.pix_base = 11'(11'(row_i[4:0]) * 11'(ScreenCols))
                       + 11'({col_i[6:0], 1'b0});
  end

  // stage B: weighted distance 3*dr^2 + 4*dg^2 + 2*db^2 per palette entry
  always_comb begin
    logic [19:0] r2, g2, b2;
    for (int i = 0; i < 16; i++) begin
      r2 = 20'(sq_r_q[tcce_pkg::PAL_LVL[i][5:4]]);
      g2 = 20'(sq_g_q[tcce_pkg::PAL_LVL[i][3:2]]);
      b2 = 20'(sq_b_q[tcce_pkg::PAL_LVL[i][1:0]]);
      dist_d[i] = (r2 << 1) + r2 + (g2 << 2) + (b2 << 1);
    end
  end

  // stage C: minimum in each group of four; strict compare keeps the lower index
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      grp_dist_d[g] = dist_q[g * 4];
      grp_idx_d[g]  = 4'(g * 4);
      for (int k = 1; k < 4; k++) begin
        if (dist_q[g * 4 + k] < grp_dist_d[g]) begin
          grp_dist_d[g] = dist_q[g * 4 + k];
          grp_idx_d[g]  = 4'(g * 4 + k);
        end
      end
    end
  end

  always_comb begin
    logic [19:0] best_d;
    best_d   = grp_dist_q[0];
    best_idx = grp_idx_q[0];
    for (int g = 1; g < 4; g++) begin
      if (grp_dist_q[g] < best_d) begin
        best_d   = grp_dist_q[g];
        best_idx = grp_idx_q[g];
      end
    end
  end

  always_comb begin
    cmd_o     = cmd_c_q;
    cmd_o.idx = best_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q <= push_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cmd_a_q    <= cmd_a_d;
      cmd_b_q    <= cmd_a_q;
      cmd_c_q    <= cmd_b_q;
      sq_r_q     <= sq_r_d;
      sq_g_q     <= sq_g_d;
      sq_b_q     <= sq_b_d;
      dist_q     <= dist_d;
      grp_dist_q <= grp_dist_d;
      grp_idx_q  <= grp_idx_d;
    end
  end

endmodule

// ----- rtl/core/tcce_back.sv -----
module tcce_back #(
  parameter int unsigned ScreenCols = tcce_pkg::SCREEN_COLS_DEF,
  parameter int unsigned ScreenRows = tcce_pkg::SCREEN_ROWS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcce_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  output tcce_pkg::res_t res_o,
  output logic           res_push_o,
  input  logic           res_full_i,
  input  logic           cfg_we_i,
  input  logic [3:0]     cfg_data_i
);

  logic       ready_q, ready_d;
  logic [6:0] col_q, col_d;
  logic [4:0] row_q, row_d;
  logic [3:0] bg_q, bg_d;
  logic [3:0] fill_idx_q;
  logic       phase_q, phase_d;
  logic       go;
  logic       split;

  assign go         = cmd_valid_i && !res_full_i;
  assign res_push_o = go;
  // a pixel block gives two transfers; keep the command for the second
  assign split      = (cmd_i.req == tcce_pkg::REQ_PIXEL) && cmd_i.pix_ok;
  assign cmd_pop_o  = go && !(split && !phase_q);
  assign phase_d    = (go && split) ? !phase_q : phase_q;

  always_comb begin
    logic [6:0] x;
    logic [4:0] y;
    logic [5:0] y_inc;
    logic [7:0] x_inc;
    logic [4:0] stop;
    logic [7:0] stop_col;
    logic       scroll;

    ready_d = ready_q;
    col_d   = col_q;
    row_d   = row_q;
    bg_d    = bg_q;
    scroll  = 1'b0;
    res_o   = '0;
    res_o.status = tcce_pkg::ST_OK;
    res_o.last   = 1'b1;

    x        = cmd_i.both_neg ? col_q : cmd_i.x;
    y        = cmd_i.both_neg ? row_q : cmd_i.y;
    y_inc    = 6'(y) + 6'd1;
    x_inc    = 8'(x) + 8'd1;
    stop     = 5'(x >> tcce_pkg::TAB_BITS) + 5'd1;
    stop_col = 8'({stop, {tcce_pkg::TAB_BITS{1'b0}}});

    unique case (cmd_i.req)
      tcce_pkg::REQ_INIT: begin
        bg_d    = '0;
        col_d   = '0;
        row_d   = '0;
        ready_d = 1'b1;
        res_o.fill_screen = 1'b1;
        res_o.fill_attr   = {4'b0, fill_idx_q};
      end
      tcce_pkg::REQ_CLEAR: begin
        bg_d  = cmd_i.idx;
        col_d = '0;
        row_d = '0;
        res_o.fill_screen = 1'b1;
        res_o.fill_attr   = {cmd_i.idx, 4'b0};
      end
      tcce_pkg::REQ_PIXEL: begin
        if (!cmd_i.pix_ok) begin
          res_o.status = tcce_pkg::ST_INVALID;
        end else begin
          res_o.cell_write = 1'b1;
          res_o.cell_index = phase_q ? cmd_i.pix_base + 11'd1 : cmd_i.pix_base;
          res_o.cell_char  = tcce_pkg::CH_BLOCK;
          res_o.cell_attr  = {cmd_i.idx, cmd_i.idx};
          res_o.last       = phase_q;
        end
      end
      tcce_pkg::REQ_PUTCHAR: begin
        priority if (!ready_q) begin
          res_o.status = tcce_pkg::ST_NOINIT;
        end else if (cmd_i.one_neg) begin
          res_o.status = tcce_pkg::ST_INVALID;
        end else begin
          unique case (cmd_i.ch)
            tcce_pkg::CH_LF: begin
              col_d = '0;
              row_d = y_inc[4:0];
              scroll = (y_inc >= 6'(ScreenRows));
            end
            tcce_pkg::CH_CR: begin
              col_d = '0;
              row_d = y;
            end
            tcce_pkg::CH_TAB: begin
              col_d = (stop_col >= 8'(ScreenCols)) ? 7'(ScreenCols - 1) : stop_col[6:0];
              row_d = y;
            end
            tcce_pkg::CH_BS: begin
              // at column 0 leave the cursor where it was
              if (x != '0) begin
                col_d = x - 7'd1;
                row_d = y;
              end
            end
            default: begin
              res_o.cell_write = 1'b1;
              res_o.cell_index = 11'(11'(y) * 11'(ScreenCols)) + 11'(x);
              res_o.cell_char  = cmd_i.ch;
              res_o.cell_attr  = {bg_q, cmd_i.idx};
              if (x_inc >= 8'(ScreenCols)) begin
                col_d  = '0;
                row_d  = y_inc[4:0];
                scroll = (y_inc >= 6'(ScreenRows));
              end else begin
                col_d = x_inc[6:0];
                row_d = y;
              end
            end
          endcase
          if (scroll) begin
            row_d = 5'(ScreenRows - 1);
            res_o.scroll_up = 1'b1;
            res_o.fill_attr = {bg_q, 4'b0};
          end
        end
      end
      default: ;
    endcase

    res_o.cursor_col = col_d;
    res_o.cursor_row = row_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q    <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      bg_q       <= '0;
      phase_q    <= 1'b0;
      fill_idx_q <= tcce_pkg::INIT_FILL_RESET;
    end else begin
      if (go) begin
        ready_q <= ready_d;
        col_q   <= col_d;
        row_q   <= row_d;
        bg_q    <= bg_d;
      end
      phase_q <= phase_d;
      if (cfg_we_i) begin
        fill_idx_q <= cfg_data_i;
      end
    end
  end

endmodule

// ----- verif/tcce_checker.sv -----
module tcce_checker
  import tcce_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // command side
  input  logic              push,
  input  logic              full,
  input  logic [1:0]        cmd_req_i,
  input  logic [7:0]        cmd_ch_i,
  input  logic signed [7:0] cmd_col_i,
  input  logic signed [7:0] cmd_row_i,
  input  logic [7:0]        cmd_red_i,
  input  logic [7:0]        cmd_green_i,
  input  logic [7:0]        cmd_blue_i,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_data_i,
  // result side
  input  logic              empty,
  input  logic              pop,
  input  logic [1:0]        res_status_i,
  input  logic              res_cell_write_i,
  input  logic [10:0]       res_cell_index_i,
  input  logic [7:0]        res_cell_char_i,
  input  logic [7:0]        res_cell_attr_i,
  input  logic              res_scroll_up_i,
  input  logic              res_fill_screen_i,
  input  logic [7:0]        res_fill_attr_i,
  input  logic [6:0]        res_cursor_col_i,
  input  logic [4:0]        res_cursor_row_i,
  input  logic              res_last_i,
  output int                err_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS      = SCREEN_COLS_DEF;
  localparam int ROWS      = SCREEN_ROWS_DEF;
  localparam int TAB_WIDTH = 8;
  localparam int MAX_PRINT = 60;

  localparam int PAL_R [16] = '{0, 0, 0, 0, 170, 170, 170, 170,
                                85, 85, 85, 85, 255, 255, 255, 255};
  localparam int PAL_G [16] = '{0, 0, 170, 170, 0, 0, 85, 170,
                                85, 85, 255, 255, 85, 85, 255, 255};
  localparam int PAL_B [16] = '{0, 170, 0, 170, 0, 170, 0, 170,
                                85, 255, 85, 255, 85, 255, 85, 255};

  // console state as seen by the predictor
  bit         ready;
  int         cur_col;
  int         cur_row;
  int         bg_idx;
  logic [3:0] fill_idx;

  res_t expected_q [$];

  initial begin
    ready       = 1'b0;
    cur_col     = 0;
    cur_row     = 0;
    bg_idx      = 0;
    fill_idx    = INIT_FILL_RESET;
    err_count_o = 0;
    pending_o   = 0;
  end

  function automatic int palette_nearest(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    int best;
    int best_d;
    int dr, dg, db, d;
    best   = 0;
    best_d = 32'h7fffffff;
    for (int i = 0; i < 16; i++) begin
      dr = int'(r) - PAL_R[i];
      dg = int'(g) - PAL_G[i];
      db = int'(b) - PAL_B[i];
      d  = 3 * dr * dr + 4 * dg * dg + 2 * db * db;
      // strict compare keeps the lowest index on a tie
      if (d < best_d) begin
        best_d = d;
        best   = i;
      end
    end
    return best;
  endfunction

  function automatic res_t blank_res(input status_e st, input logic is_last);
    res_t res;
    res            = '0;
    res.status     = st;
    res.cursor_col = 7'(cur_col);
    res.cursor_row = 5'(cur_row);
    res.last       = is_last;
    return res;
  endfunction

  task automatic predict_cmd(input req_e req, input logic [7:0] ch,
                             input logic signed [7:0] col, input logic signed [7:0] row,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    res_t res;
    int   idx, cx, cy, x, y, base, stop;
    bit   wrote, scrolled;
    idx      = palette_nearest(r, g, b);
    cx       = col;
    cy       = row;
    wrote    = 1'b0;
    scrolled = 1'b0;
    case (req)
      REQ_INIT: begin
        bg_idx  = 0;
        cur_col = 0;
        cur_row = 0;
        ready   = 1'b1;
        res = blank_res(ST_OK, 1'b1);
        res.fill_screen = 1'b1;
        res.fill_attr   = {4'h0, fill_idx};
        expected_q.push_back(res);
      end
      REQ_CLEAR: begin
        bg_idx  = idx;
        cur_col = 0;
        cur_row = 0;
        res = blank_res(ST_OK, 1'b1);
        res.fill_screen = 1'b1;
        res.fill_attr   = 8'(idx << 4);
        expected_q.push_back(res);
      end
      REQ_PIXEL: begin
        if (cx < 0 || cx >= COLS / 2 || cy < 0 || cy >= ROWS) begin
          expected_q.push_back(blank_res(ST_INVALID, 1'b1));
        end else begin
          base = cy * COLS + cx * 2;
          for (int k = 0; k < 2; k++) begin
            res = blank_res(ST_OK, k == 1);
            res.cell_write = 1'b1;
            res.cell_index = 11'(base + k);
            res.cell_char  = CH_BLOCK;
            res.cell_attr  = 8'(idx * 17);
            expected_q.push_back(res);
          end
        end
      end
      default: begin
        if (!ready) begin
          expected_q.push_back(blank_res(ST_NOINIT, 1'b1));
        end else if ((cx < 0) != (cy < 0)) begin
          expected_q.push_back(blank_res(ST_INVALID, 1'b1));
        end else begin
          if (cx < 0) begin
            x = cur_col;
            y = cur_row;
          end else begin
            x = (cx >= COLS) ? COLS - 1 : cx;
            y = (cy >= ROWS) ? ROWS - 1 : cy;
          end
          if (ch == CH_LF) begin
            cur_col = 0;
            cur_row = y + 1;
            if (cur_row >= ROWS) scrolled = 1'b1;
          end else if (ch == CH_CR) begin
            cur_col = 0;
            cur_row = y;
          end else if (ch == CH_TAB) begin
            stop = (x / TAB_WIDTH + 1) * TAB_WIDTH;
            if (stop >= COLS) stop = COLS - 1;
            cur_col = stop;
            cur_row = y;
          end else if (ch == CH_BS) begin
            // at column 0 the cursor stays where it was, even for explicit coords
            if (x > 0) begin
              cur_col = x - 1;
              cur_row = y;
            end
          end else begin
            wrote   = 1'b1;
            cur_col = x + 1;
            cur_row = y;
            if (cur_col >= COLS) begin
              cur_col = 0;
              cur_row++;
              if (cur_row >= ROWS) scrolled = 1'b1;
            end
          end
          if (scrolled) cur_row = ROWS - 1;
          res = blank_res(ST_OK, 1'b1);
          if (wrote) begin
            res.cell_write = 1'b1;
            res.cell_index = 11'(y * COLS + x);
            res.cell_char  = ch;
            res.cell_attr  = 8'((bg_idx << 4) | idx);
          end
          if (scrolled) begin
            res.scroll_up = 1'b1;
            res.fill_attr = 8'(bg_idx << 4);
          end
          expected_q.push_back(res);
        end
      end
    endcase
  endtask

  task automatic report_error(input string msg);
    if (err_count_o < MAX_PRINT) $display("[%0t] ERROR: %s", $realtime, msg);
    err_count_o++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          report_error("result transfer with nothing expected");
        end else begin
          want = expected_q.pop_front();
          check_field("status", res_status_i, want.status);
          check_field("cell_write", res_cell_write_i, want.cell_write);
          check_field("cell_index", res_cell_index_i, want.cell_index);
          check_field("cell_char", res_cell_char_i, want.cell_char);
          check_field("cell_attr", res_cell_attr_i, want.cell_attr);
          check_field("scroll_up", res_scroll_up_i, want.scroll_up);
          check_field("fill_screen", res_fill_screen_i, want.fill_screen);
          check_field("fill_attr", res_fill_attr_i, want.fill_attr);
          check_field("cursor_col", res_cursor_col_i, want.cursor_col);
          check_field("cursor_row", res_cursor_row_i, want.cursor_row);
          check_field("last", res_last_i, want.last);
        end
      end
      if (push && !full) begin
        predict_cmd(req_e'(cmd_req_i), cmd_ch_i, cmd_col_i, cmd_row_i,
                    cmd_red_i, cmd_green_i, cmd_blue_i);
      end
      // only written while idle, so no command sees it in the same cycle
      if (cfg_we_i) fill_idx = cfg_data_i;
      pending_o = expected_q.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tcce_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 250;

  logic              clk;
  logic              rst_n;
  logic              push;
  logic              full;
  logic [1:0]        req_type;
  logic [7:0]        ch;
  logic signed [7:0] col;
  logic signed [7:0] row;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic              cfg_we;
  logic [3:0]        cfg_data;
  logic              empty;
  logic              pop;
  logic [1:0]        status;
  logic              cell_write;
  logic [10:0]       cell_index;
  logic [7:0]        cell_char;
  logic [7:0]        cell_attr;
  logic              scroll_up;
  logic              fill_screen;
  logic [7:0]        fill_attr;
  logic [6:0]        cursor_col;
  logic [4:0]        cursor_row;
  logic              last;

  int err_count;
  int pending;
  int cycle_cnt;
  bit send_idle;
  bit recv_idle;
  int hold_cycles;

  text_console_cursor_engine u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type),
    .ch_i          (ch),
    .col_i         (col),
    .row_i         (row),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status),
    .cell_write_o  (cell_write),
    .cell_index_o  (cell_index),
    .cell_char_o   (cell_char),
    .cell_attr_o   (cell_attr),
    .scroll_up_o   (scroll_up),
    .fill_screen_o (fill_screen),
    .fill_attr_o   (fill_attr),
    .cursor_col_o  (cursor_col),
    .cursor_row_o  (cursor_row),
    .last_o        (last)
  );

  tcce_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .push              (push),
    .full              (full),
    .cmd_req_i         (req_type),
    .cmd_ch_i          (ch),
    .cmd_col_i         (col),
    .cmd_row_i         (row),
    .cmd_red_i         (red),
    .cmd_green_i       (green),
    .cmd_blue_i        (blue),
    .cfg_we_i          (cfg_we),
    .cfg_data_i        (cfg_data),
    .empty             (empty),
    .pop               (pop),
    .res_status_i      (status),
    .res_cell_write_i  (cell_write),
    .res_cell_index_i  (cell_index),
    .res_cell_char_i   (cell_char),
    .res_cell_attr_i   (cell_attr),
    .res_scroll_up_i   (scroll_up),
    .res_fill_screen_i (fill_screen),
    .res_fill_attr_i   (fill_attr),
    .res_cursor_col_i  (cursor_col),
    .res_cursor_row_i  (cursor_row),
    .res_last_i        (last),
    .err_count_o       (err_count),
    .pending_o         (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random pop gaps, plus one long hold-off on request
  initial begin
    int gap;
    int n;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        pop         = 1'b0;
        n           = hold_cycles;
        hold_cycles = 0;
        repeat (n) @(negedge clk);
      end
      gap = recv_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  function automatic logic [7:0] rand_comp();
    int sel;
    int lvl;
    sel = $urandom_range(0, 9);
    lvl = 85 * $urandom_range(0, 3);
    if (sel < 4) return 8'($urandom_range(0, 255));
    if (sel < 7) return 8'(lvl);
    // land close to a level so ties and near misses show up
    lvl = lvl + $urandom_range(0, 84) - 42;
    if (lvl < 0) lvl = 0;
    if (lvl > 255) lvl = 255;
    return 8'(lvl);
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_cmd(input req_e req, input logic [7:0] c, input int x, input int y,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      push     = 1'b0;
      // junk on the fields while no transfer is offered
      req_type = 2'($urandom_range(0, 3));
      ch       = 8'($urandom);
      col      = 8'($urandom);
      row      = 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    req_type = req;
    ch       = c;
    col      = 8'(x);
    row      = 8'(y);
    red      = r;
    green    = g;
    blue     = b;
    push     = 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic send_random();
    int   sel;
    int   x, y;
    req_e req;
    logic [7:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 65) req = REQ_PUTCHAR;
    else if (sel < 73) req = REQ_INIT;
    else if (sel < 80) req = REQ_CLEAR;
    else req = REQ_PIXEL;

    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      case ($urandom_range(0, 3))
        0: c = CH_LF;
        1: c = CH_CR;
        2: c = CH_TAB;
        default: c = CH_BS;
      endcase
    end else begin
      c = 8'($urandom_range(0, 255));
    end

    sel = $urandom_range(0, 99);
    if (req == REQ_PIXEL && sel < 70) begin
      x = $urandom_range(0, 41);
      y = $urandom_range(0, 26);
    end else if (sel < 55) begin
      x = -int'($urandom_range(1, 128));
      y = -int'($urandom_range(1, 128));
    end else if (sel < 80) begin
      x = $urandom_range(0, 85);
      y = $urandom_range(0, 27);
    end else if (sel < 90) begin
      x = $urandom_range(0, 1) ? -int'($urandom_range(1, 128)) : $urandom_range(0, 127);
      y = (x < 0) ? $urandom_range(0, 127) : -int'($urandom_range(1, 128));
    end else begin
      x = int'($urandom_range(0, 255)) - 128;
      y = int'($urandom_range(0, 255)) - 128;
    end
    send_cmd(req, c, x, y, rand_comp(), rand_comp(), rand_comp());
  endtask

  task automatic write_fill(input logic [3:0] v);
    // drop the offer so nothing new enters while the queues drain
    push = 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_data = 4'($urandom);
  endtask

  initial begin
    logic [3:0] fill_vals [5];
    push        = 1'b0;
    req_type    = REQ_PUTCHAR;
    ch          = '0;
    col         = '0;
    row         = '0;
    red         = '0;
    green       = '0;
    blue        = '0;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    send_idle   = 1'b1;
    recv_idle   = 1'b1;
    hold_cycles = 0;
    cycle_cnt   = 0;
    rst_n       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset fill index still in effect
    send_cmd(REQ_PUTCHAR, "A", -1, -1, 8'd255, 8'd255, 8'd255);   // not initialized
    send_cmd(REQ_PIXEL, 8'd0, 0, 0, 8'd255, 8'd255, 8'd255);
    send_cmd(REQ_PIXEL, 8'd0, 39, 24, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_PIXEL, 8'd0, 40, 0, 8'd170, 8'd85, 8'd0);
    send_cmd(REQ_PIXEL, 8'd0, -1, 0, 8'd0, 8'd0, 8'd170);
    send_cmd(REQ_PIXEL, 8'd0, 127, -128, 8'd0, 8'd0, 8'd170);
    send_cmd(REQ_PIXEL, 8'd0, 0, 25, 8'd0, 8'd0, 8'd170);
    send_cmd(REQ_CLEAR, 8'd0, 0, 0, 8'd170, 8'd0, 8'd0);
    send_cmd(REQ_INIT, 8'd0, 0, 0, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_PUTCHAR, "A", -1, -1, 8'd255, 8'd255, 8'd255);
    send_cmd(REQ_PUTCHAR, CH_BS, -1, -1, 8'd128, 8'd128, 8'd128);
    send_cmd(REQ_PUTCHAR, CH_BS, -1, -1, 8'd42, 8'd43, 8'd42);
    send_cmd(REQ_PUTCHAR, CH_TAB, -1, -1, 8'd0, 8'd255, 8'd0);
    send_cmd(REQ_PUTCHAR, CH_TAB, 75, 3, 8'd0, 8'd255, 8'd0);
    send_cmd(REQ_PUTCHAR, CH_TAB, 79, 3, 8'd0, 8'd255, 8'd0);
    send_cmd(REQ_PUTCHAR, CH_CR, -1, -1, 8'd0, 8'd0, 8'd255);
    send_cmd(REQ_PUTCHAR, CH_LF, 5, 24, 8'd255, 8'd0, 8'd255);
    send_cmd(REQ_PUTCHAR, "z", 79, 24, 8'd85, 8'd255, 8'd85);
    send_cmd(REQ_PUTCHAR, 8'd255, 127, 127, 8'd255, 8'd255, 8'd85);
    send_cmd(REQ_PUTCHAR, 8'd0, 0, 0, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_PUTCHAR, "x", -1, 3, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_PUTCHAR, "x", 3, -128, 8'd0, 8'd0, 8'd0);
    send_cmd(REQ_PUTCHAR, CH_LF, -128, -128, 8'd85, 8'd85, 8'd255);
    send_cmd(REQ_CLEAR, 8'd0, -1, -1, 8'd255, 8'd255, 8'd255);

    fill_vals[0] = 4'd0;
    fill_vals[1] = 4'd15;
    fill_vals[2] = 4'($urandom);
    fill_vals[3] = 4'd7;
    fill_vals[4] = 4'($urandom);
    for (int p = 0; p < 5; p++) begin
      write_fill(fill_vals[p]);
      send_idle = (p != 3);
      recv_idle = (p != 3);
      // long receiver stall while commands keep coming: fills both queues
      if (p == 1) hold_cycles = 200;
      repeat (PHASE_ITEMS) send_random();
    end
    push = 1'b0;

    wait (pending == 0);
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
